// File: rtl/assert_macros.svh
// assertion helpers used by gdil_fifo
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define GDIL_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define GDIL_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error("assertion failed");

`endif

// File: rtl/gdil_pkg.sv
// ----------------------------------------------------------------------------
// gdil_pkg
// Types, constants and helpers of the grayscale dilation block.
// ----------------------------------------------------------------------------
`default_nettype none

package gdil_pkg;

  localparam int MAX_KERNEL    = 7;
  localparam int DEF_MAX_WIDTH = 2048;
  localparam int SLOT_W        = 3;
  localparam int KDIM_W        = 3;
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_W    = 2;
  localparam int FIFO_CNT_W    = 3;

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_KERNEL_WIDTH  = 3'd1,
    REG_KERNEL_HEIGHT = 3'd2,
    REG_KERNEL_MASK   = 3'd3,
    REG_ROI_LEFT      = 3'd4,
    REG_ROI_TOP       = 3'd5,
    REG_ROI_RIGHT     = 3'd6,
    REG_ROI_BOTTOM    = 3'd7
  } cfg_reg_t;

  localparam logic [11:0] RST_IMAGE_WIDTH = 12'd640;
  localparam logic [2:0]  RST_KERNEL_DIM  = 3'd3;
  localparam logic [48:0] RST_KERNEL_MASK = 49'd511;
  localparam logic [11:0] RST_ROI_RIGHT   = 12'd640;
  localparam logic [11:0] RST_ROI_BOTTOM  = 12'd480;

  typedef struct packed {
    logic [7:0] pixel;
    logic       pad;
    logic       start_of_frame;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  value;
    logic [10:0] col;
    logic [10:0] row;
  } out_pix_t;

  typedef struct packed {
    logic [11:0]       image_width;
    logic [KDIM_W-1:0] kernel_width;
    logic [KDIM_W-1:0] kernel_height;
    logic [11:0]       roi_left;
    logic [11:0]       roi_top;
    logic [11:0]       roi_right;
    logic [11:0]       roi_bottom;
  } geom_t;

  // active elements indexed by rows up and columns back from the newest beat
  typedef logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0] act_map_t;

  // partial result handed from front to back
  typedef struct packed {
    logic [MAX_KERNEL-1:0][7:0] row_max;
    logic [MAX_KERNEL-1:0]      row_any;
    logic [7:0]                 anchor;
    logic [10:0]                col;
    logic [10:0]                row;
  } part_t;

  function automatic logic [KDIM_W-1:0] kdim_clamp(input logic [KDIM_W-1:0] k);
    kdim_clamp = (k == '0) ? KDIM_W'(1) : k;
  endfunction

  // rows or columns of the kernel that lie past the anchor
  function automatic logic [KDIM_W-1:0] kdim_ext(input logic [KDIM_W-1:0] k);
    kdim_ext = (k - KDIM_W'(1)) - (k >> 1);
  endfunction

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s,
                                                 input logic wrapped);
    if (wrapped || s == SLOT_W'(MAX_KERNEL - 1)) begin
      slot_inc = '0;
    end else begin
      slot_inc = s + SLOT_W'(1);
    end
  endfunction

  function automatic logic [SLOT_W-1:0] slot_sub(input logic [SLOT_W-1:0] s,
                                                 input logic [SLOT_W-1:0] d);
    logic [SLOT_W:0] t;
    t = (s >= d) ? ({1'b0, s} - {1'b0, d})
                 : ({1'b0, s} + (SLOT_W + 1)'(MAX_KERNEL) - {1'b0, d});
    slot_sub = t[SLOT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/gdil_fifo.sv
// ----------------------------------------------------------------------------
// gdil_fifo
// Short queue of partial results between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module gdil_fifo (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            push,
  input  gdil_pkg::part_t                push_data,
  input  wire                            pop,
  output gdil_pkg::part_t                pop_data,
  output logic                           empty,
  output logic [gdil_pkg::FIFO_CNT_W-1:0] count
);
  import gdil_pkg::*;

  part_t                 store_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + FIFO_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + FIFO_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = store_r[rd_ptr_r];
  assign empty    = (count_r == '0);
  assign count    = count_r;

  `GDIL_ASSERT_IMP(a_no_overflow, clk, rst_n, push && !pop, count_r < FIFO_CNT_W'(FIFO_DEPTH))
  `GDIL_ASSERT_IMP(a_no_underflow, clk, rst_n, pop, count_r != '0)
  `GDIL_ASSERT(a_count_bound, clk, rst_n, count_r <= FIFO_CNT_W'(FIFO_DEPTH))

endmodule

`default_nettype wire

// File: rtl/gdil_front.sv
// ----------------------------------------------------------------------------
// gdil_front
// Position counters, line store, window and per-row masked maxima.
// ----------------------------------------------------------------------------
`default_nettype none

module gdil_front #(
  parameter int MAX_WIDTH = gdil_pkg::DEF_MAX_WIDTH
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  gdil_pkg::in_beat_t              in_data,
  input  gdil_pkg::geom_t                 geom,
  input  gdil_pkg::act_map_t              act,
  input  wire [gdil_pkg::FIFO_CNT_W-1:0]  fifo_count,
  output logic                            push,
  output gdil_pkg::part_t                 push_data
);
  import gdil_pkg::*;

  localparam int DEPTH = MAX_WIDTH + MAX_KERNEL;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = (AW > 12) ? AW : 12;

  logic [KDIM_W-1:0] kw_c, kh_c, ext_r, ext_b;
  logic [CW-1:0]     iw, w_c, ext_w;

  logic [AW-1:0]     col_r, col_nxt;
  logic [11:0]       row_r, row_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;

  logic [AW-1:0]     c_a;
  logic [11:0]       r_a, y_a;
  logic [SLOT_W-1:0] s_a;
  logic [CW-1:0]     c_b, x_a;
  logic              prod_a;
  logic [7:0]        pix_a;
  logic [MAX_KERNEL-1:0] rowlt_a;
  logic              acc;
  logic [FIFO_CNT_W:0] inflight;

  // stage 0: beat placed, store read issued
  logic              v0_r, prod0_r, first0_r;
  logic [SLOT_W-1:0] slot0_r;
  logic [MAX_KERNEL-1:0] rowlt0_r;
  logic [7:0]        pix0_r;
  logic [10:0]       x0_r, y0_r;
  logic [7:0]        rd [MAX_KERNEL];

  // stage 1: window
  logic              v1_r, prod1_r;
  logic [10:0]       x1_r, y1_r;
  logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][7:0] win_r, win_nxt;

  always_comb begin
    kw_c  = kdim_clamp(geom.kernel_width);
    kh_c  = kdim_clamp(geom.kernel_height);
    ext_r = kdim_ext(kw_c);
    ext_b = kdim_ext(kh_c);
    iw    = CW'(geom.image_width);
    if (iw == '0) begin
      w_c = CW'(1);
    end else if (iw > CW'(MAX_WIDTH)) begin
      w_c = CW'(MAX_WIDTH);
    end else begin
      w_c = iw;
    end
    ext_w = w_c + CW'(ext_r);
  end

  assign inflight = (FIFO_CNT_W + 1)'(fifo_count) + (FIFO_CNT_W + 1)'(v0_r & prod0_r)
                  + (FIFO_CNT_W + 1)'(v1_r & prod1_r);
  assign in_stall = (inflight >= (FIFO_CNT_W + 1)'(FIFO_DEPTH));
  assign acc      = in_valid && !in_stall;

  always_comb begin
    c_a = in_data.start_of_frame ? '0 : col_r;
    r_a = in_data.start_of_frame ? '0 : row_r;
    s_a = in_data.start_of_frame ? '0 : slot_r;
    // width shrank mid-row: begin a fresh row
    if (CW'(c_a) >= ext_w) begin
      c_a = '0;
      r_a = r_a + 12'd1;
      s_a = slot_inc(s_a, r_a == '0);
    end
    c_b = CW'(c_a) + CW'(1);
    if (c_b >= ext_w) begin
      col_nxt  = '0;
      row_nxt  = r_a + 12'd1;
      slot_nxt = slot_inc(s_a, row_nxt == '0);
    end else begin
      col_nxt  = c_b[AW-1:0];
      row_nxt  = r_a;
      slot_nxt = s_a;
    end
    y_a    = r_a - 12'(ext_b);
    x_a    = CW'(c_a) - CW'(ext_r);
    prod_a = (r_a >= 12'(ext_b)) && (CW'(c_a) >= CW'(ext_r))
          && (y_a >= geom.roi_top) && (y_a < geom.roi_bottom)
          && (x_a >= CW'(geom.roi_left)) && (x_a < CW'(geom.roi_right));
    pix_a  = in_data.pad ? 8'd0 : in_data.pixel;
    for (int d = 0; d < MAX_KERNEL; d++) begin
      rowlt_a[d] = (r_a < 12'(d));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      slot_r <= '0;
      v0_r   <= 1'b0;
      v1_r   <= 1'b0;
    end else begin
      v0_r <= acc;
      v1_r <= v0_r;
      if (acc) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        slot_r <= slot_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      prod0_r  <= prod_a;
      first0_r <= (c_a == '0);
      slot0_r  <= s_a;
      rowlt0_r <= rowlt_a;
      pix0_r   <= pix_a;
      x0_r     <= x_a[10:0];
      y0_r     <= y_a[10:0];
    end
    prod1_r <= prod0_r;
    x1_r    <= x0_r;
    y1_r    <= y0_r;
  end

  // one line memory per row slot, all read at the current column
  for (genvar g = 0; g < MAX_KERNEL; g++) begin : g_line
    logic [7:0] mem [DEPTH];
    logic [7:0] rd_q;
    always_ff @(posedge clk) begin
      if (acc && s_a == SLOT_W'(g)) begin
        mem[c_a] <= pix_a;
      end
    end
    always_ff @(posedge clk) begin
      if (acc) begin
        rd_q <= mem[c_a];
      end
    end
    assign rd[g] = rd_q;
  end

  always_comb begin
    win_nxt = win_r;
    for (int d = 0; d < MAX_KERNEL; d++) begin
      for (int k = MAX_KERNEL - 1; k > 0; k--) begin
        win_nxt[d][k] = first0_r ? 8'd0 : win_r[d][k-1];
      end
      if (d == 0) begin
        win_nxt[d][0] = pix0_r;
      end else if (rowlt0_r[d]) begin
        win_nxt[d][0] = 8'd0;
      end else begin
        win_nxt[d][0] = rd[slot_sub(slot0_r, SLOT_W'(d))];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (v0_r) begin
      win_r <= win_nxt;
    end
  end

  always_comb begin
    push_data = '0;
    for (int d = 0; d < MAX_KERNEL; d++) begin
      for (int k = 0; k < MAX_KERNEL; k++) begin
        if (act[d][k] && win_r[d][k] >= push_data.row_max[d]) begin
          push_data.row_max[d] = win_r[d][k];
        end
      end
      push_data.row_any[d] = |act[d];
    end
    push_data.anchor = win_r[ext_b][ext_r];
    push_data.col    = x1_r;
    push_data.row    = y1_r;
  end

  assign push = v1_r && prod1_r;

endmodule

`default_nettype wire

// File: rtl/gdil_back.sv
// ----------------------------------------------------------------------------
// gdil_back
// Final maximum over the row partials and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gdil_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 fifo_empty,
  input  gdil_pkg::part_t     fifo_data,
  output logic                pop,
  output logic                out_valid,
  input  wire                 out_stall,
  output gdil_pkg::out_pix_t  out_data
);
  import gdil_pkg::*;

  logic     out_valid_r, out_valid_nxt;
  out_pix_t out_data_r, out_data_nxt;
  logic [7:0] best;

  always_comb begin
    best = 8'd0;
    for (int d = 0; d < MAX_KERNEL; d++) begin
      if (fifo_data.row_any[d] && fifo_data.row_max[d] > best) begin
        best = fifo_data.row_max[d];
      end
    end
  end

  always_comb begin
    pop           = !fifo_empty && (!out_valid_r || !out_stall);
    out_valid_nxt = pop ? 1'b1 : (out_valid_r && out_stall);
    out_data_nxt  = out_data_r;
    if (pop) begin
      // empty mask falls back to the anchor
      out_data_nxt.value = (|fifo_data.row_any) ? best : fifo_data.anchor;
      out_data_nxt.col   = fifo_data.col;
      out_data_nxt.row   = fifo_data.row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: rtl/grayscale_dilation_masked_kernel.sv
// ----------------------------------------------------------------------------
// grayscale_dilation_masked_kernel
// 8-bit grayscale dilation with a masked structuring element up to 7x7.
// ----------------------------------------------------------------------------
// Usage: pixels enter in raster order over the extended frame on in_valid /
// in_stall / in_data, with pad marking extension beats and start_of_frame the
// first beat. Each beat whose output position lies inside the ROI yields one
// result on out_valid / out_stall / out_data (value, col, row).
// Registers are written on cfg_valid / cfg_ready, always ready; the user must
// write them only while idle, as the block itself does not enforce this.
// Throughput: one beat per cycle while in_stall is low, set by the single
// write and read port of each of the seven line memories. An accepted beat
// passes the store read, window, queue and output register in that order.
// While the receiver stalls the output holds; the four-entry queue fills and
// in_stall rises once queued plus in-flight results reach its depth.
// Reset (rst_n low, synchronous) restores the register defaults, clears the
// position counters and empties the queue; line memories are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module grayscale_dilation_masked_kernel #(
  parameter int MAX_WIDTH = gdil_pkg::DEF_MAX_WIDTH
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  gdil_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output gdil_pkg::out_pix_t  out_data,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire [2:0]           cfg_index,
  input  wire [48:0]          cfg_data
);
  import gdil_pkg::*;

  geom_t       geom_r;
  logic [48:0] mask_r;
  act_map_t    act_r, act_nxt;
  logic [KDIM_W-1:0] kw_c, kh_c;
  logic [5:0]  bit_idx;

  logic                  push, pop, fifo_empty;
  part_t                 push_data, fifo_data;
  logic [FIFO_CNT_W-1:0] fifo_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geom_r.image_width   <= RST_IMAGE_WIDTH;
      geom_r.kernel_width  <= RST_KERNEL_DIM;
      geom_r.kernel_height <= RST_KERNEL_DIM;
      geom_r.roi_left      <= '0;
      geom_r.roi_top       <= '0;
      geom_r.roi_right     <= RST_ROI_RIGHT;
      geom_r.roi_bottom    <= RST_ROI_BOTTOM;
      mask_r               <= RST_KERNEL_MASK;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:   geom_r.image_width   <= cfg_data[11:0];
        REG_KERNEL_WIDTH:  geom_r.kernel_width  <= cfg_data[2:0];
        REG_KERNEL_HEIGHT: geom_r.kernel_height <= cfg_data[2:0];
        REG_KERNEL_MASK:   mask_r               <= cfg_data;
        REG_ROI_LEFT:      geom_r.roi_left      <= cfg_data[11:0];
        REG_ROI_TOP:       geom_r.roi_top       <= cfg_data[11:0];
        REG_ROI_RIGHT:     geom_r.roi_right     <= cfg_data[11:0];
        REG_ROI_BOTTOM:    geom_r.roi_bottom    <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // remap the mask to rows up / columns back from the newest beat
  always_comb begin
    kw_c    = kdim_clamp(geom_r.kernel_width);
    kh_c    = kdim_clamp(geom_r.kernel_height);
    act_nxt = '0;
    bit_idx = '0;
    for (int d = 0; d < MAX_KERNEL; d++) begin
      for (int k = 0; k < MAX_KERNEL; k++) begin
        bit_idx = 6'((kh_c - KDIM_W'(1) - KDIM_W'(d)) * kw_c)
                + 6'(kw_c - KDIM_W'(1) - KDIM_W'(k));
        act_nxt[d][k] = (KDIM_W'(d) < kh_c) && (KDIM_W'(k) < kw_c) && mask_r[bit_idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    act_r <= act_nxt;
  end

  gdil_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .geom       (geom_r),
    .act        (act_r),
    .fifo_count (fifo_count),
    .push       (push),
    .push_data  (push_data)
  );

  gdil_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (fifo_data),
    .empty     (fifo_empty),
    .count     (fifo_count)
  );

  gdil_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_empty (fifo_empty),
    .fifo_data  (fifo_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire
